### rtl/silhouette_edge_finder_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the silhouette edge finder
// Shared property forms, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SILHOUETTE_EDGE_FINDER_UNIT_DEFINES_SVH
`define SILHOUETTE_EDGE_FINDER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SEF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SEF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sef_pkg.sv
// ----------------------------------------------------------------------------
// Silhouette edge finder package
// Shared constants, command codes and payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package sef_pkg;

  localparam int unsigned MaxVertices    = 1024;
  localparam int unsigned EdgesPerVertex = 32;
  localparam int unsigned VtxW           = $clog2(MaxVertices);
  localparam int unsigned SlotW          = $clog2(EdgesPerVertex);
  localparam int unsigned CntW           = $clog2(EdgesPerVertex + 1);
  localparam int unsigned EdgeAddrW      = VtxW + SlotW;
  localparam int unsigned EdgeW          = VtxW + 1;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgLightX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLightY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLightZ = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_TRI   = 2'd2,
    CMD_SCAN  = 2'd3
  } cmd_e;

  // A position or light direction: three signed 16-bit components.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec_t;

  // Status from the facing unit.
  typedef struct packed {
    logic done;
    logic lit;
  } fac_stat_t;

endpackage

`default_nettype wire

### rtl/sef_if.sv
// ----------------------------------------------------------------------------
// Silhouette edge finder channels
// Command channel and result channel, each valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface sef_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [9:0]                index_a;
  logic [9:0]                index_b;
  logic [9:0]                index_c;
  logic signed [15:0]        pos_x;
  logic signed [15:0]        pos_y;
  logic signed [15:0]        pos_z;

  modport source (output valid, cmd, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, cmd, index_a, index_b, index_c, pos_x, pos_y, pos_z,
                  output ready);
endinterface

interface sef_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] edge_from;
  logic [9:0] edge_to;
  logic       edge_found;
  logic       run_last;

  modport source (output valid, edge_from, edge_to, edge_found, run_last, input ready);
  modport sink   (input valid, edge_from, edge_to, edge_found, run_last, output ready);
endinterface

`default_nettype wire

### rtl/silhouette_edge_finder_unit.sv
// ----------------------------------------------------------------------------
// Silhouette edge finder
// Keeps vertex positions and per-vertex directed edge lists in on-chip
// memories and reports the silhouette edges around a scanned vertex.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake       Carries
//  in_if     sink       valid/ready     cmd, index_a/b/c, pos_x/y/z
//  out_if    source     valid/ready     edge_from, edge_to, edge_found, run_last
//  cfg       input      cfg_we_i        light_x/y/z by cfg_idx_i
//
//  Load writes the vertex memory in the accepting cycle; add triangle passes
//  through the accepting cycle, three vertex reads, the facing unit and three
//  count read-modify-writes.
//  Clear and reset sweep the 1024-entry count memory, one entry a cycle, so
//  the block accepts no command until the sweep ends.
//  Scan reads the vertex's edge count, then each listed edge in turn; a lit
//  edge adds a read of its reverse list's count and a compare of each entry
//  of that list, and releasing a held edge adds a push step. Entries are read
//  one at a time through the single read port of the edge memory. A full
//  result register stalls the scan until out_if.ready takes the transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module silhouette_edge_finder_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  sef_in_if.sink                            in_if,
  sef_out_if.source                         out_if,
  input  wire logic                         cfg_we_i,
  input  wire logic [sef_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sef_pkg::CfgDataW-1:0] cfg_data_i
);
  import sef_pkg::*;
  `include "silhouette_edge_finder_unit_defines.svh"

  typedef enum logic [14:0] {
    S_CLEAR    = 15'h0001,
    S_IDLE     = 15'h0002,
    S_TRI_RD   = 15'h0004,
    S_TRI_WAIT = 15'h0008,
    S_APP_RD   = 15'h0010,
    S_APP_WR   = 15'h0020,
    S_SC_START = 15'h0040,
    S_SC_CNT   = 15'h0080,
    S_SC_NEXT  = 15'h0100,
    S_SC_EDGE  = 15'h0200,
    S_SC_RCNT  = 15'h0400,
    S_SC_RNEXT = 15'h0800,
    S_SC_REV   = 15'h1000,
    S_SC_PUSH  = 15'h2000,
    S_SC_END   = 15'h4000
  } state_e;

  localparam logic [CntW-1:0] CntMax  = CntW'(EdgesPerVertex);
  localparam logic [VtxW-1:0] LastVtx = VtxW'(MaxVertices - 1);

  // Memories.
  vec_t                vmem [MaxVertices];
  logic [CntW-1:0]     cmem [MaxVertices];
  logic [EdgeW-1:0]    emem [MaxVertices * EdgesPerVertex];

  logic                v_we;
  logic [VtxW-1:0]     v_raddr;
  vec_t                vrd_q;
  logic                c_we;
  logic [VtxW-1:0]     c_waddr, c_raddr;
  logic [CntW-1:0]     c_wdata, crd_q;
  logic                e_we;
  logic [EdgeAddrW-1:0] e_waddr, e_raddr;
  logic [EdgeW-1:0]    e_wdata, erd_q;

  state_e              state_q, state_d;
  logic [VtxW-1:0]     clr_q, clr_d;
  logic [VtxW-1:0]     a_q, a_d, b_q, b_d, c_q, c_d;
  logic [1:0]          rd_q, rd_d;
  vec_t                pa_q, pa_d, pb_q, pb_d;
  logic                lit_q, lit_d;
  logic [1:0]          app_q, app_d;
  logic [CntW-1:0]     j_q, j_d, k_q, k_d, cnt_q, cnt_d, rcnt_q, rcnt_d;
  logic [VtxW-1:0]     to_q, to_d, pend_q, pend_d;
  logic                pend_v_q, pend_v_d;
  vec_t                light_q;

  logic                ov_q, ov_d, ofound_q, ofound_d, olast_q, olast_d;
  logic [VtxW-1:0]     ofrom_q, ofrom_d, oto_q, oto_d;
  logic                out_free;
  logic                in_acc;
  logic [VtxW-1:0]     app_from, app_to;
  logic                fac_start;
  fac_stat_t           fac;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !ov_q || out_if.ready;

  // Edge endpoints of the current append: A->B, B->C, C->A.
  always_comb begin
    unique case (app_q)
      2'd0:    begin app_from = a_q; app_to = b_q; end
      2'd1:    begin app_from = b_q; app_to = c_q; end
      default: begin app_from = c_q; app_to = a_q; end
    endcase
  end

  sef_facing u_facing (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fac_start),
    .pos_a_i (pa_q),
    .pos_b_i (pb_q),
    .pos_c_i (vrd_q),
    .light_i (light_q),
    .stat_o  (fac)
  );

  // Command sequencer.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    rd_d     = rd_q;
    pa_d     = pa_q;
    pb_d     = pb_q;
    lit_d    = lit_q;
    app_d    = app_q;
    j_d      = j_q;
    k_d      = k_q;
    cnt_d    = cnt_q;
    rcnt_d   = rcnt_q;
    to_d     = to_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    ov_d     = ov_q && !out_if.ready;
    ofrom_d  = ofrom_q;
    oto_d    = oto_q;
    ofound_d = ofound_q;
    olast_d  = olast_q;
    v_we     = 1'b0;
    v_raddr  = a_q;
    c_we     = 1'b0;
    c_waddr  = app_from;
    c_wdata  = crd_q + CntW'(1);
    c_raddr  = app_from;
    e_we     = 1'b0;
    e_waddr  = {app_from, crd_q[SlotW-1:0]};
    e_wdata  = {lit_q, app_to};
    e_raddr  = {a_q, j_q[SlotW-1:0]};
    fac_start = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_q;
        c_wdata = '0;
        clr_d   = clr_q + VtxW'(1);
        if (clr_q == LastVtx) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          a_d = in_if.index_a;
          b_d = in_if.index_b;
          c_d = in_if.index_c;
          unique case (cmd_e'(in_if.cmd))
            CMD_CLEAR: begin clr_d = '0; state_d = S_CLEAR; end
            CMD_LOAD:  v_we = 1'b1;
            CMD_TRI:   begin rd_d = '0; state_d = S_TRI_RD; end
            CMD_SCAN:  begin pend_v_d = 1'b0; state_d = S_SC_START; end
            default:   state_d = S_IDLE;
          endcase
        end
      end
      // Read corners A, B, C; C arrives as the facing unit starts.
      S_TRI_RD: begin
        rd_d = rd_q + 2'd1;
        unique case (rd_q)
          2'd0:    v_raddr = a_q;
          2'd1:    begin pa_d = vrd_q; v_raddr = b_q; end
          2'd2:    begin pb_d = vrd_q; v_raddr = c_q; end
          default: begin fac_start = 1'b1; state_d = S_TRI_WAIT; end
        endcase
      end
      S_TRI_WAIT: begin
        if (fac.done) begin
          lit_d   = fac.lit;
          app_d   = '0;
          state_d = S_APP_RD;
        end
      end
      S_APP_RD: state_d = S_APP_WR;
      // Append when the list has room, else drop the edge.
      S_APP_WR: begin
        if (crd_q < CntMax) begin
          e_we = 1'b1;
          c_we = 1'b1;
        end
        if (app_q == 2'd2) begin
          state_d = S_IDLE;
        end else begin
          app_d   = app_q + 2'd1;
          state_d = S_APP_RD;
        end
      end
      S_SC_START: begin
        c_raddr = a_q;
        state_d = S_SC_CNT;
      end
      S_SC_CNT: begin
        cnt_d   = crd_q;
        j_d     = '0;
        state_d = S_SC_NEXT;
      end
      S_SC_NEXT: begin
        e_raddr = {a_q, j_q[SlotW-1:0]};
        state_d = (j_q == cnt_q) ? S_SC_END : S_SC_EDGE;
      end
      // Forward edge: look up the reverse list only for a lit one.
      S_SC_EDGE: begin
        if (erd_q[EdgeW-1]) begin
          to_d    = erd_q[VtxW-1:0];
          c_raddr = erd_q[VtxW-1:0];
          state_d = S_SC_RCNT;
        end else begin
          j_d     = j_q + CntW'(1);
          state_d = S_SC_NEXT;
        end
      end
      S_SC_RCNT: begin
        rcnt_d  = crd_q;
        k_d     = '0;
        state_d = S_SC_RNEXT;
      end
      S_SC_RNEXT: begin
        e_raddr = {to_q, k_q[SlotW-1:0]};
        if (k_q == rcnt_q) begin
          // No lit reverse edge: this is a silhouette edge.
          if (pend_v_q) begin
            state_d = S_SC_PUSH;
          end else begin
            pend_d   = to_q;
            pend_v_d = 1'b1;
            j_d      = j_q + CntW'(1);
            state_d  = S_SC_NEXT;
          end
        end else begin
          state_d = S_SC_REV;
        end
      end
      S_SC_REV: begin
        if (erd_q[EdgeW-1] && (erd_q[VtxW-1:0] == a_q)) begin
          j_d     = j_q + CntW'(1);
          state_d = S_SC_NEXT;
        end else begin
          k_d     = k_q + CntW'(1);
          state_d = S_SC_RNEXT;
        end
      end
      // Release the held edge now that a later one exists.
      S_SC_PUSH: begin
        if (out_free) begin
          ov_d     = 1'b1;
          ofrom_d  = a_q;
          oto_d    = pend_q;
          ofound_d = 1'b1;
          olast_d  = 1'b0;
          pend_d   = to_q;
          j_d      = j_q + CntW'(1);
          state_d  = S_SC_NEXT;
        end
      end
      // Final transaction: the held edge, or the empty marker.
      S_SC_END: begin
        if (out_free) begin
          ov_d     = 1'b1;
          ofrom_d  = a_q;
          oto_d    = pend_v_q ? pend_q : '0;
          ofound_d = pend_v_q;
          olast_d  = 1'b1;
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_if.ready       = (state_q == S_IDLE);
  assign out_if.valid      = ov_q;
  assign out_if.edge_from  = ofrom_q;
  assign out_if.edge_to    = oto_q;
  assign out_if.edge_found = ofound_q;
  assign out_if.run_last   = olast_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      rd_q      <= '0;
      app_q     <= '0;
      j_q       <= '0;
      k_q       <= '0;
      pend_v_q  <= 1'b0;
      ov_q      <= 1'b0;
      light_q.x <= 16'sd0;
      light_q.y <= 16'sd0;
      light_q.z <= 16'sd16384;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      rd_q     <= rd_d;
      app_q    <= app_d;
      j_q      <= j_d;
      k_q      <= k_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgLightX: light_q.x <= cfg_data_i;
          CfgLightY: light_q.y <= cfg_data_i;
          CfgLightZ: light_q.z <= cfg_data_i;
          default:   light_q   <= light_q;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    lit_q    <= lit_d;
    cnt_q    <= cnt_d;
    rcnt_q   <= rcnt_d;
    to_q     <= to_d;
    pend_q   <= pend_d;
    ofrom_q  <= ofrom_d;
    oto_q    <= oto_d;
    ofound_q <= ofound_d;
    olast_q  <= olast_d;
  end

  // Vertex position memory.
  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vmem[in_if.index_a] <= '{x: in_if.pos_x, y: in_if.pos_y, z: in_if.pos_z};
    end
    vrd_q <= vmem[v_raddr];
  end

  // Edge count memory.
  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    crd_q <= cmem[c_raddr];
  end

  // Edge list memory.
  always_ff @(posedge clk_i) begin
    if (e_we) emem[e_waddr] <= e_wdata;
    erd_q <= emem[e_raddr];
  end

  `SEF_ASSERT_IMP(a_cnt_bound, c_we, c_wdata <= CntMax, "edge count beyond list size")
  `SEF_ASSERT_IMP(a_append_room, e_we, crd_q < CntMax, "edge written to a full list")
  `SEF_ASSERT_IMP(a_fac_done, fac.done, state_q == S_TRI_WAIT, "facing result unexpected")
  `SEF_ASSERT_NXT(a_push_valid, (state_q == S_SC_END) && out_free, ov_q && olast_q,
                  "final scan transaction not presented")

endmodule

`default_nettype wire

### rtl/sef_facing.sv
// ----------------------------------------------------------------------------
// Triangle facing unit
// Computes sign((B-A) x (C-A) . L) with one shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module sef_facing (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire sef_pkg::vec_t  pos_a_i,
  input  wire sef_pkg::vec_t  pos_b_i,
  input  wire sef_pkg::vec_t  pos_c_i,
  input  wire sef_pkg::vec_t  light_i,
  output sef_pkg::fac_stat_t  stat_o
);
  import sef_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_ACC  = 3'b100
  } fstate_e;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
  } dvec_t;

  localparam logic [3:0] LastStep = 4'd8;

  fstate_e            state_q, state_d;
  logic [3:0]         step_q, step_d;
  dvec_t              d1_q, d1_d, d2_q, d2_d;
  logic signed [33:0] n0_q, n0_d, n1_q, n1_d, n2_q, n2_d;
  logic signed [51:0] prod_q, prod_d, acc_q, acc_d;
  logic               done_q, done_d, lit_q, lit_d;
  logic signed [34:0] op_a;
  logic signed [16:0] op_b;
  logic signed [51:0] acc_base;
  logic               first_step, sub_step;

  // Operand selection for the step sequence: six cross-product terms, then the dot.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      4'd0: begin op_a = 35'(d1_q.y); op_b = d2_q.z; end
      4'd1: begin op_a = 35'(d1_q.z); op_b = d2_q.y; end
      4'd2: begin op_a = 35'(d1_q.z); op_b = d2_q.x; end
      4'd3: begin op_a = 35'(d1_q.x); op_b = d2_q.z; end
      4'd4: begin op_a = 35'(d1_q.x); op_b = d2_q.y; end
      4'd5: begin op_a = 35'(d1_q.y); op_b = d2_q.x; end
      4'd6: begin op_a = 35'(n0_q);   op_b = 17'(light_i.x); end
      4'd7: begin op_a = 35'(n1_q);   op_b = 17'(light_i.y); end
      4'd8: begin op_a = 35'(n2_q);   op_b = 17'(light_i.z); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign first_step = (step_q == 4'd0) || (step_q == 4'd2) || (step_q == 4'd4) ||
                      (step_q == 4'd6);
  assign sub_step   = (step_q == 4'd1) || (step_q == 4'd3) || (step_q == 4'd5);
  assign acc_base   = first_step ? '0 : acc_q;

  // Sequencer: multiply in F_MUL, accumulate in F_ACC.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    d1_d    = d1_q;
    d2_d    = d2_q;
    n0_d    = n0_q;
    n1_d    = n1_q;
    n2_d    = n2_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    lit_d   = lit_q;
    unique case (state_q)
      F_IDLE: begin
        if (start_i) begin
          d1_d.x  = 17'(pos_b_i.x) - 17'(pos_a_i.x);
          d1_d.y  = 17'(pos_b_i.y) - 17'(pos_a_i.y);
          d1_d.z  = 17'(pos_b_i.z) - 17'(pos_a_i.z);
          d2_d.x  = 17'(pos_c_i.x) - 17'(pos_a_i.x);
          d2_d.y  = 17'(pos_c_i.y) - 17'(pos_a_i.y);
          d2_d.z  = 17'(pos_c_i.z) - 17'(pos_a_i.z);
          step_d  = '0;
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        prod_d  = op_a * op_b;
        state_d = F_ACC;
      end
      F_ACC: begin
        acc_d = sub_step ? (acc_base - prod_q) : (acc_base + prod_q);
        if (step_q == 4'd1) n0_d = acc_d[33:0];
        if (step_q == 4'd3) n1_d = acc_d[33:0];
        if (step_q == 4'd5) n2_d = acc_d[33:0];
        if (step_q == LastStep) begin
          lit_d   = (acc_d > 52'sd0);
          done_d  = 1'b1;
          state_d = F_IDLE;
        end else begin
          step_d  = step_q + 4'd1;
          state_d = F_MUL;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    d1_q   <= d1_d;
    d2_q   <= d2_d;
    n0_q   <= n0_d;
    n1_q   <= n1_d;
    n2_q   <= n2_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    lit_q  <= lit_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.lit  = lit_q;

endmodule

`default_nettype wire
